/* src/rtwe_pkg.sv */
package rtwe_pkg;

    localparam int CAPACITY  = 128;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 160;
    localparam int ENTRY_W   = KEY_W + 64 + 32 + 32;
    localparam logic [7:0] MAX_RESET = 8'd100;

    localparam logic [2:0] K_REGISTER   = 3'd0;
    localparam logic [2:0] K_LOOKUP     = 3'd1;
    localparam logic [2:0] K_GRACE_KEY  = 3'd2;
    localparam logic [2:0] K_GRACE_PEER = 3'd3;
    localparam logic [2:0] K_UNREG_PEER = 3'd4;
    localparam logic [2:0] K_SWEEP      = 3'd5;
    localparam logic [2:0] K_QUERY      = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;

    typedef struct packed {
        logic [159:0] key;
        logic [63:0]  peer;
        logic [31:0]  expiry;
        logic [31:0]  grace;
    } t_entry;

endpackage

/* src/rtwe_ram.sv */
module rtwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* src/relay_table_with_expiry_and_grace.sv */
// relay table with expiry and grace deadlines
// command channel: i_start with the command fields is a transfer when o_busy
// is low; o_busy rises the next cycle and falls in the cycle in which o_done
// strobes.
// result channel: o_done strobes for one cycle with status, counts, peer
// tag and expiry; the receiver cannot stall, so results are never held.
// the user must write max_entries by i_cfg_we / i_cfg_data only while idle;
// the block itself has no check that enforces this.
// every command walks all CAPACITY slots of the entry memory: one read is
// issued per cycle and the data returns in the following cycle, where it is
// checked and, if needed, rewritten in the same cycle. then S_FINAL does
// the key write and latches the result, and S_OUT follows; o_busy stays
// high through all of this on every command and o_done strobes in the
// cycle after S_OUT. a new command can be taken at the edge ending that
// cycle, so commands never overlap.
// valid and grace bits live in flip-flops, cleared at reset, so entry data
// needs no clearing pass; payload memory is undefined until written.
// during the scan a write lands in the slot just read, never in the one being
// fetched, so read and write never touch the same slot at once.
// after reset the table is empty and max_entries is 100.
module relay_table_with_expiry_and_grace
    import rtwe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_node_id_hi,
    input  logic [63:0] i_node_id_mid,
    input  logic [63:0] i_node_id_lo,
    input  logic [63:0] i_peer_tag,
    input  logic [31:0] i_expiry_time,
    input  logic [31:0] i_grace_deadline,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_count,
    output logic [7:0]  o_grace_count,
    output logic [63:0] o_found_peer_tag,
    output logic [31:0] o_found_expiry
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FINAL = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // command latch
    logic [2:0]   r_kind;
    logic [31:0]  r_now;
    logic [159:0] r_key;
    logic [63:0]  r_peer;
    logic [31:0]  r_exp;
    logic [31:0]  r_grace;
    logic [7:0]   r_max;

    // flag arrays
    logic [CAPACITY-1:0] r_valid;
    logic [CAPACITY-1:0] r_gset;
    logic [CNT_W-1:0]    r_live;

    // scan pointers: r_ra fetches, r_chk marks data due in this cycle
    logic [IDX_W:0]   r_ra;
    logic             r_chk;
    logic [IDX_W-1:0] r_ci;

    // search results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [63:0]      r_hit_peer;
    logic [31:0]      r_hit_exp;
    logic             r_hit_gset;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_gcnt;

    // memory
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    t_entry           mem_rdata;

    // next result fields
    logic [1:0]  n_status;
    logic [7:0]  n_count;
    logic [7:0]  n_grace_count;
    logic [63:0] n_found_peer_tag;
    logic [31:0] n_found_expiry;

    rtwe_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ra[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    // per-slot checks on returned data
    logic v_ok, key_eq, peer_eq, expired, gdead, gpend;
    assign v_ok    = r_chk && r_valid[r_ci];
    assign key_eq  = mem_rdata.key == r_key;
    assign peer_eq = mem_rdata.peer == r_peer;
    assign expired = r_now >= mem_rdata.expiry;
    assign gdead   = r_gset[r_ci] && (r_now >= mem_rdata.grace);
    assign gpend   = !expired && r_gset[r_ci] && (r_now < mem_rdata.grace);

    logic scan_mark;    // grace by peer hits this slot
    logic scan_remove;  // unregister or sweep hits this slot
    logic key_grace;    // grace by key may apply at final step
    logic reg_new;      // register of a new key may go ahead

    always_comb begin
        scan_mark   = 1'b0;
        scan_remove = 1'b0;
        if (r_state == S_SCAN && v_ok) begin
            case (r_kind)
                K_GRACE_PEER: scan_mark   = peer_eq && !expired;
                K_UNREG_PEER: scan_remove = peer_eq;
                K_SWEEP:      scan_remove = expired || gdead;
                default: ;
            endcase
        end
    end

    assign key_grace = r_hit && (r_now < r_hit_exp);
    assign reg_new   = !r_hit && ({{(16-CNT_W){1'b0}}, r_live} < {8'd0, r_max})
                       && r_free;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_ci;
        mem_wdata = mem_rdata;
        if (scan_mark) begin
            mem_we          = 1'b1;
            mem_wdata.grace = r_grace;
        end else if (r_state == S_FINAL) begin
            if (r_kind == K_REGISTER && (r_hit || reg_new)) begin
                mem_we           = 1'b1;
                mem_waddr        = r_hit ? r_hit_idx : r_free_idx;
                mem_wdata.key    = r_key;
                mem_wdata.peer   = r_peer;
                mem_wdata.expiry = r_exp;
                mem_wdata.grace  = '0;
            end else if (r_kind == K_GRACE_KEY && key_grace) begin
                // key and expiry are rewritten as last read for this slot
                mem_we           = 1'b1;
                mem_waddr        = r_hit_idx;
                mem_wdata.key    = r_key;
                mem_wdata.peer   = r_hit_peer;
                mem_wdata.expiry = r_hit_exp;
                mem_wdata.grace  = r_grace;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start) n_state = S_SCAN;
            S_SCAN:  if (!r_chk && r_ra[IDX_W]) n_state = S_FINAL;
            S_FINAL: n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= MAX_RESET;
            r_valid <= '0;
            r_gset  <= '0;
            r_live  <= '0;
            r_chk   <= 1'b0;
            r_ra    <= '0;
            o_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            // strobe registered from S_OUT, which follows the result latch in S_FINAL
            o_done  <= (r_state == S_OUT);
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    r_ra  <= '0;
                    r_chk <= 1'b0;
                end
                S_SCAN: begin
                    r_chk <= !r_ra[IDX_W];
                    if (!r_ra[IDX_W]) begin
                        r_ra <= r_ra + 1'b1;
                    end
                    if (scan_mark) begin
                        r_gset[r_ci] <= 1'b1;
                    end
                    if (scan_remove) begin
                        r_valid[r_ci] <= 1'b0;
                        r_gset[r_ci]  <= 1'b0;
                        r_live        <= r_live - 1'b1;
                    end
                end
                S_FINAL: begin
                    if (r_kind == K_REGISTER) begin
                        if (r_hit) begin
                            r_gset[r_hit_idx] <= 1'b0;
                        end else if (reg_new) begin
                            r_valid[r_free_idx] <= 1'b1;
                            r_gset[r_free_idx]  <= 1'b0;
                            r_live              <= r_live + 1'b1;
                        end
                    end else if (r_kind == K_GRACE_KEY && key_grace) begin
                        r_gset[r_hit_idx] <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // command latch and scan accumulators
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_kind  <= i_kind;
            r_now   <= i_now_time;
            r_key   <= {i_node_id_hi, i_node_id_mid, i_node_id_lo};
            r_peer  <= i_peer_tag;
            r_exp   <= i_expiry_time;
            r_grace <= i_grace_deadline;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_cnt   <= '0;
            r_gcnt  <= '0;
            r_hit_idx  <= '0;
            r_free_idx <= '0;
        end
        r_ci <= r_ra[IDX_W-1:0];
        if (r_state == S_SCAN && r_chk) begin
            if (v_ok && key_eq && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_ci;
                r_hit_peer <= mem_rdata.peer;
                r_hit_exp  <= mem_rdata.expiry;
                r_hit_gset <= r_gset[r_ci];
            end
            if (!r_valid[r_ci] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_ci;
            end
            if (scan_mark || (r_kind == K_SWEEP && scan_remove)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (v_ok && gpend) begin
                r_gcnt <= r_gcnt + 1'b1;
            end
        end
    end

    // result formatting
    always_comb begin
        n_status         = ST_OK;
        n_count          = '0;
        n_grace_count    = '0;
        n_found_peer_tag = '0;
        n_found_expiry   = '0;
        case (r_kind)
            K_REGISTER: if (!r_hit && !reg_new) n_status = ST_FULL;
            K_LOOKUP: begin
                if (!r_hit || !(r_now < r_hit_exp) || r_hit_gset) begin
                    n_status = ST_ABSENT;
                end else begin
                    n_found_peer_tag = r_hit_peer;
                    n_found_expiry   = r_hit_exp;
                end
            end
            K_GRACE_KEY: begin
                if (key_grace) n_count  = 8'd1;
                else           n_status = ST_ABSENT;
            end
            K_GRACE_PEER, K_SWEEP: n_count = 8'(r_cnt);
            K_QUERY: begin
                n_count       = 8'(r_live);
                n_grace_count = 8'(r_gcnt);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINAL) begin
            o_status         <= n_status;
            o_count          <= n_count;
            o_grace_count    <= n_grace_count;
            o_found_peer_tag <= n_found_peer_tag;
            o_found_expiry   <= n_found_expiry;
        end
    end

endmodule

/* src/rtwe_checker.sv */
module rtwe_checker
    import rtwe_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [7:0] o_count,
    input logic [7:0] o_grace_count
);
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy missing after transfer");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy))
        else $error("result without command");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status != 2'd3 && o_count <= 8'(CAPACITY)
                    && o_grace_count <= 8'(CAPACITY)))
        else $error("result out of range");
endmodule

bind relay_table_with_expiry_and_grace rtwe_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_count       (o_count),
    .o_grace_count (o_grace_count)
);
